@@ rtl/ssc_pkg.sv @@
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, register indexes and helpers for the six-step commutator.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OFFSET = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_POLES  = 2'd2;

  localparam int GAIN_BITS      = 16;
  localparam int OFFSET_BITS    = 12;
  localparam int POLE_BITS      = 5;
  localparam int GAIN_FRAC_BITS = 8;

  localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = 16'd1151;
  localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 12'd423;
  localparam logic [POLE_BITS-1:0]   POLES_RESET  = 5'd7;

  // step count before the modulo never exceeds 2 * 31 * 6
  localparam int STEP_BITS   = 9;
  localparam int SECTOR_BITS = 3;

  localparam logic [SECTOR_BITS-1:0] SECTOR_0 = 3'd0;
  localparam logic [SECTOR_BITS-1:0] SECTOR_1 = 3'd1;
  localparam logic [SECTOR_BITS-1:0] SECTOR_2 = 3'd2;
  localparam logic [SECTOR_BITS-1:0] SECTOR_3 = 3'd3;
  localparam logic [SECTOR_BITS-1:0] SECTOR_4 = 3'd4;
  localparam logic [SECTOR_BITS-1:0] SECTOR_5 = 3'd5;

  typedef struct packed {
    logic neg;
    logic clamped;
  } duty_flags_t;

  // x mod 6: reciprocal 85/512 undershoots the quotient by at most one
  function automatic logic [SECTOR_BITS-1:0] mod6(input logic [STEP_BITS-1:0] x);
    logic [15:0]          p;
    logic [STEP_BITS-1:0] q;
    logic [STEP_BITS-1:0] r;
    p = 16'(x) * 16'd85;
    q = STEP_BITS'(p[15:9]);
    r = x - STEP_BITS'(q * 9'd6);
    if (r >= 9'd6) begin
      r = r - 9'd6;
    end
    return r[SECTOR_BITS-1:0];
  endfunction

endpackage

@@ rtl/ssc_duty.sv @@
// ----------------------------------------------------------------------------
// ssc_duty
// Three-stage proportional duty path: error, gain multiply, scale and clamp.
// ----------------------------------------------------------------------------
module ssc_duty #(
  parameter int ANGLE_BITS = 12,
  parameter int DUTY_BITS  = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [ANGLE_BITS-1:0]        reference_angle,
  input  logic [ANGLE_BITS-1:0]        measured_angle,
  input  logic [ssc_pkg::GAIN_BITS-1:0] gain,
  output logic                         out_valid,
  output logic [DUTY_BITS-1:0]         mag,
  output ssc_pkg::duty_flags_t         flags
);
  import ssc_pkg::*;

  localparam int EW = ANGLE_BITS + 1;
  localparam int PW = EW + GAIN_BITS + 1;
  localparam int DW = PW - GAIN_FRAC_BITS;
  localparam int CW = (DW > DUTY_BITS + 2) ? DW : DUTY_BITS + 2;
  localparam logic signed [CW-1:0] LIM_POS = CW'((2 ** DUTY_BITS) - 1);
  localparam logic signed [CW-1:0] LIM_NEG = -LIM_POS;

  logic                 v1, v2;
  logic signed [EW-1:0] err;
  logic signed [PW-1:0] prod;
  logic signed [DW-1:0] duty;
  logic signed [CW-1:0] dext;
  logic [DUTY_BITS-1:0] mag_next;
  duty_flags_t          flags_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    err   <= signed'({1'b0, reference_angle}) - signed'({1'b0, measured_angle});
    prod  <= PW'(err) * PW'(signed'({1'b0, gain}));
    mag   <= mag_next;
    flags <= flags_next;
  end

  // arithmetic shift is floor division by 256
  always_comb begin
    duty = DW'(prod >>> GAIN_FRAC_BITS);
    dext = CW'(duty);
    flags_next = '0;
    priority if (dext > LIM_POS) begin
      mag_next           = LIM_POS[DUTY_BITS-1:0];
      flags_next.clamped = 1'b1;
    end else if (dext < LIM_NEG) begin
      mag_next           = LIM_POS[DUTY_BITS-1:0];
      flags_next.neg     = 1'b1;
      flags_next.clamped = 1'b1;
    end else if (dext < 0) begin
      mag_next       = DUTY_BITS'(-dext);
      flags_next.neg = 1'b1;
    end else begin
      mag_next = DUTY_BITS'(dext);
    end
  end

endmodule

@@ rtl/six_step_position_commutator.sv @@
// ----------------------------------------------------------------------------
// six_step_position_commutator
// Proportional position loop with six-step phase commutation.
// ----------------------------------------------------------------------------
// One angle pair is taken every clock cycle; its result is flagged by done
// for a single cycle. The depth is set by four register stages: angle error
// and offset sum, the gain and pole-pair multiplies, scaling with clamp and
// the times-six step count, then sector modulo and the commutation table into
// the output registers. The receiver cannot hold results off, so busy stays
// low and nothing stalls. Configuration writes are always accepted (cfg_ready
// high) and should only be issued with no transfer in flight; unknown register
// indexes are dropped.
module six_step_position_commutator #(
  parameter int ANGLE_BITS = 12,
  parameter int DUTY_BITS  = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  // command side
  input  logic                             start,
  output logic                             busy,
  input  logic [ANGLE_BITS-1:0]            reference_angle,
  input  logic [ANGLE_BITS-1:0]            measured_angle,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ssc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ssc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // results
  output logic                             done,
  output logic [DUTY_BITS-1:0]             drive_u,
  output logic [DUTY_BITS-1:0]             drive_v,
  output logic [DUTY_BITS-1:0]             drive_w,
  output logic                             enable_u,
  output logic                             enable_v,
  output logic                             enable_w,
  output logic [ssc_pkg::SECTOR_BITS-1:0]  sector,
  output logic                             duty_clamped
);
  import ssc_pkg::*;

  // offset register keeps no more bits than the angle itself
  localparam int OFF_BITS = (ANGLE_BITS < OFFSET_BITS) ? ANGLE_BITS : OFFSET_BITS;
  localparam int SUM_BITS = ANGLE_BITS + 1;
  localparam int SP_BITS  = SUM_BITS + POLE_BITS;
  localparam int S6_BITS  = SP_BITS + 3;

  // configuration registers
  logic [GAIN_BITS-1:0] gain;
  logic [OFF_BITS-1:0]  offset;
  logic [POLE_BITS-1:0] poles;

  // sector path
  logic [SUM_BITS-1:0]  sum;
  logic [SP_BITS-1:0]   sp;
  logic [S6_BITS-1:0]   sp6;
  logic [STEP_BITS-1:0] steps;
  logic [STEP_BITS-1:0] steps_next;

  // duty path
  logic                 v3;
  logic [DUTY_BITS-1:0] mag;
  duty_flags_t          flags;

  // stage four
  logic [DUTY_BITS-1:0]   pwm, ret;
  logic [SECTOR_BITS-1:0] sector_next;
  logic [DUTY_BITS-1:0]   drive_u_next, drive_v_next, drive_w_next;
  logic                   enable_u_next, enable_v_next, enable_w_next;

  logic accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // register writes, bits above each register's width are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      gain   <= GAIN_RESET;
      offset <= OFF_BITS'(OFFSET_RESET);
      poles  <= POLES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GAIN:   gain   <= cfg_data[GAIN_BITS-1:0];
        CFG_OFFSET: offset <= cfg_data[OFF_BITS-1:0];
        CFG_POLES:  poles  <= cfg_data[POLE_BITS-1:0];
        default:    ;
      endcase
    end
  end

  ssc_duty #(
    .ANGLE_BITS (ANGLE_BITS),
    .DUTY_BITS  (DUTY_BITS)
  ) u_duty (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (accept),
    .reference_angle (reference_angle),
    .measured_angle  (measured_angle),
    .gain            (gain),
    .out_valid       (v3),
    .mag             (mag),
    .flags           (flags)
  );

  // offset sum, pole-pair multiply, then times six and drop the angle bits
  assign sp6        = {1'b0, sp, 2'b00} + {2'b00, sp, 1'b0};
  assign steps_next = sp6[ANGLE_BITS +: STEP_BITS];

  always_ff @(posedge clk) begin
    sum   <= SUM_BITS'(measured_angle) + SUM_BITS'(offset);
    sp    <= SP_BITS'(sum) * SP_BITS'(poles);
    steps <= steps_next;
  end

  // commutation table: one phase floats, the others take pwm and return legs
  always_comb begin
    sector_next   = mod6(steps);
    pwm           = flags.neg ? '0 : mag;
    ret           = flags.neg ? mag : '0;
    drive_u_next  = '0;
    drive_v_next  = '0;
    drive_w_next  = '0;
    enable_u_next = 1'b0;
    enable_v_next = 1'b0;
    enable_w_next = 1'b0;
    unique case (sector_next)
      SECTOR_0: begin
        drive_v_next = ret; drive_w_next = pwm;
        enable_v_next = 1'b1; enable_w_next = 1'b1;
      end
      SECTOR_1: begin
        drive_u_next = ret; drive_w_next = pwm;
        enable_u_next = 1'b1; enable_w_next = 1'b1;
      end
      SECTOR_2: begin
        drive_u_next = ret; drive_v_next = pwm;
        enable_u_next = 1'b1; enable_v_next = 1'b1;
      end
      SECTOR_3: begin
        drive_v_next = pwm; drive_w_next = ret;
        enable_v_next = 1'b1; enable_w_next = 1'b1;
      end
      SECTOR_4: begin
        drive_u_next = pwm; drive_w_next = ret;
        enable_u_next = 1'b1; enable_w_next = 1'b1;
      end
      default: begin
        // sector five
        drive_u_next = pwm; drive_v_next = ret;
        enable_u_next = 1'b1; enable_v_next = 1'b1;
      end
    endcase
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
  end

  // result payload, loaded only with a live item
  always_ff @(posedge clk) begin
    if (v3) begin
      drive_u      <= drive_u_next;
      drive_v      <= drive_v_next;
      drive_w      <= drive_w_next;
      enable_u     <= enable_u_next;
      enable_v     <= enable_v_next;
      enable_w     <= enable_w_next;
      sector       <= sector_next;
      duty_clamped <= flags.clamped;
    end
  end

  // every result comes from an earlier start transfer
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 4))
    else $error("result without matching start transfer");

  // exactly two phases are driven in each result
  a_two_enables: assert property (@(posedge clk) disable iff (rst)
    done |-> $countones({enable_u, enable_v, enable_w}) == 2)
    else $error("commutation drives other than two phases");

  // a floating phase carries no duty
  a_float_zero: assert property (@(posedge clk) disable iff (rst)
    done |-> ((enable_u || drive_u == '0) && (enable_v || drive_v == '0)
              && (enable_w || drive_w == '0)))
    else $error("floating phase has nonzero drive");

  // sector stays within the six steps
  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    done |-> sector < 3'd6)
    else $error("sector out of range");

endmodule

@@ dv/six_step_position_commutator_test.sv @@
// ----------------------------------------------------------------------------
// six_step_position_commutator_test
// Self-checking bench for the six-step position commutator: angle pairs go in
// through the start/busy command port, and a built-in predictor of duty,
// clamp, sector and phase table checks every done-strobed result in order.
// ----------------------------------------------------------------------------
module six_step_position_commutator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ssc_pkg::*;

  localparam int ANGLE_BITS    = 12;
  localparam int DUTY_BITS     = 10;
  // delay from a start transfer to its result
  localparam int LATENCY       = 4;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 95;
  localparam longint DUTY_LIMIT = (longint'(1) << DUTY_BITS) - 1;
  localparam int ANGLE_TOP     = (1 << ANGLE_BITS) - 1;

  // the index past the last register, writes to it must be dropped
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;

  // one commutation result as it appears on the result ports
  typedef struct packed {
    logic [DUTY_BITS-1:0]   drive_u;
    logic [DUTY_BITS-1:0]   drive_v;
    logic [DUTY_BITS-1:0]   drive_w;
    logic                   enable_u;
    logic                   enable_v;
    logic                   enable_w;
    logic [SECTOR_BITS-1:0] sector;
    logic                   duty_clamped;
  } commutation_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [ANGLE_BITS-1:0]     reference_angle;
  logic [ANGLE_BITS-1:0]     measured_angle;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      done;
  logic [DUTY_BITS-1:0]      drive_u;
  logic [DUTY_BITS-1:0]      drive_v;
  logic [DUTY_BITS-1:0]      drive_w;
  logic                      enable_u;
  logic                      enable_v;
  logic                      enable_w;
  logic [SECTOR_BITS-1:0]    sector;
  logic                      duty_clamped;

  // predictor's own copy of the register file
  logic [GAIN_BITS-1:0]   gain_setting;
  logic [OFFSET_BITS-1:0] offset_setting;
  logic [POLE_BITS-1:0]   pole_setting;

  // commutations predicted for accepted angle pairs, oldest first
  commutation_t pending_commutations[$];

  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned cycle_count;

  six_step_position_commutator #(
    .ANGLE_BITS(ANGLE_BITS),
    .DUTY_BITS (DUTY_BITS)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .reference_angle(reference_angle),
    .measured_angle (measured_angle),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .drive_u        (drive_u),
    .drive_v        (drive_v),
    .drive_w        (drive_w),
    .enable_u       (enable_u),
    .enable_v       (enable_v),
    .enable_w       (enable_w),
    .sector         (sector),
    .duty_clamped   (duty_clamped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // proportional duty, clamp, sector choice and the six-step phase table
  function automatic commutation_t predict_commutation(
    input logic [ANGLE_BITS-1:0] ref_angle,
    input logic [ANGLE_BITS-1:0] meas_angle
  );
    longint       angle_error;
    longint       duty;
    longint       steps;
    logic [DUTY_BITS-1:0] pwm_leg;
    logic [DUTY_BITS-1:0] return_leg;
    commutation_t c;
    c = '0;
    // error is not wrapped, so it spans a full turn either way
    angle_error = longint'(ref_angle) - longint'(meas_angle);
    // arithmetic shift of a signed product rounds towards minus infinity
    duty = (angle_error * longint'(gain_setting)) >>> GAIN_FRAC_BITS;
    // only a duty strictly past the limit raises the flag
    if (duty > DUTY_LIMIT) begin
      duty = DUTY_LIMIT;
      c.duty_clamped = 1'b1;
    end else if (duty < -DUTY_LIMIT) begin
      duty = -DUTY_LIMIT;
      c.duty_clamped = 1'b1;
    end
    pwm_leg    = (duty > 0) ? DUTY_BITS'(duty) : '0;
    return_leg = (duty < 0) ? DUTY_BITS'(-duty) : '0;
    // offset sum kept unwrapped, pole pairs used as written, zero included
    steps = ((longint'(meas_angle) + longint'(offset_setting)) * longint'(pole_setting)
             * 6) >> ANGLE_BITS;
    c.sector = SECTOR_BITS'(steps % 6);
    // floating phase keeps drive and enable at zero
    case (c.sector)
      SECTOR_0: begin
        c.drive_v = return_leg; c.drive_w = pwm_leg;
        c.enable_v = 1'b1; c.enable_w = 1'b1;
      end
      SECTOR_1: begin
        c.drive_u = return_leg; c.drive_w = pwm_leg;
        c.enable_u = 1'b1; c.enable_w = 1'b1;
      end
      SECTOR_2: begin
        c.drive_u = return_leg; c.drive_v = pwm_leg;
        c.enable_u = 1'b1; c.enable_v = 1'b1;
      end
      SECTOR_3: begin
        c.drive_v = pwm_leg; c.drive_w = return_leg;
        c.enable_v = 1'b1; c.enable_w = 1'b1;
      end
      SECTOR_4: begin
        c.drive_u = pwm_leg; c.drive_w = return_leg;
        c.enable_u = 1'b1; c.enable_w = 1'b1;
      end
      default: begin
        c.drive_u = pwm_leg; c.drive_v = return_leg;
        c.enable_u = 1'b1; c.enable_v = 1'b1;
      end
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string field, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                result_count, field, got, want));
    end
  endtask

  // every done strobe is one result transfer, compared against the oldest prediction
  always @(posedge clk) begin
    commutation_t want;
    if (!rst && done === 1'b1) begin
      if (pending_commutations.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing predicted",
                                  result_count));
      end else begin
        want = pending_commutations.pop_front();
        check_field("drive_u", 16'(drive_u), 16'(want.drive_u));
        check_field("drive_v", 16'(drive_v), 16'(want.drive_v));
        check_field("drive_w", 16'(drive_w), 16'(want.drive_w));
        check_field("enable_u", 16'(enable_u), 16'(want.enable_u));
        check_field("enable_v", 16'(enable_v), 16'(want.enable_v));
        check_field("enable_w", 16'(enable_w), 16'(want.enable_w));
        check_field("sector", 16'(sector), 16'(want.sector));
        check_field("duty_clamped", 16'(duty_clamped), 16'(want.duty_clamped));
      end
      result_count++;
    end
  end

  // run guard, well above the slowest legal run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one angle pair, held until the start transfer happens
  task automatic send_angles(input logic [ANGLE_BITS-1:0] ref_angle,
                             input logic [ANGLE_BITS-1:0] meas_angle);
    @(negedge clk);
    start           = 1'b1;
    reference_angle = ref_angle;
    measured_angle  = meas_angle;
    do @(posedge clk); while (busy !== 1'b0);
    pending_commutations.push_back(predict_commutation(ref_angle, meas_angle));
  endtask

  // start low for a number of cycles before the next item
  task automatic hold_off(input int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // mostly back to back or short, now and then a long pause
  function automatic int unsigned random_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // let every transfer in flight come out before touching registers
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_commutations.size() > 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // one register transfer; the predictor keeps only the register's width
  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (index)
      CFG_GAIN:   gain_setting   = data[GAIN_BITS-1:0];
      CFG_OFFSET: offset_setting = data[OFFSET_BITS-1:0];
      CFG_POLES:  pole_setting   = data[POLE_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset register values: full-scale errors both ways, zero and unit errors,
  // then a sweep of measured angle that lands on all six sectors
  task automatic test_reset_config();
    int k;
    send_angles(ANGLE_BITS'(ANGLE_TOP), '0);
    hold_off(random_gap());
    send_angles('0, ANGLE_BITS'(ANGLE_TOP));
    hold_off(random_gap());
    send_angles(ANGLE_BITS'(2048), ANGLE_BITS'(2048));
    // minus one count must round down, not towards zero
    send_angles('0, ANGLE_BITS'(1));
    send_angles(ANGLE_BITS'(1), '0);
    for (k = 0; k < 8; k++) begin
      hold_off(random_gap());
      send_angles(ANGLE_BITS'($urandom), ANGLE_BITS'(k * 341));
    end
  endtask

  // clamp boundary, zero gain, register extremes, truncated and ignored writes
  task automatic test_register_settings();
    wait_idle();
    // unity gain puts the limit exactly at an error of 1023
    write_register(CFG_GAIN, 16'd256);
    write_register(CFG_OFFSET, 16'd0);
    write_register(CFG_POLES, 16'd1);
    send_angles(ANGLE_BITS'(1023), '0);
    send_angles(ANGLE_BITS'(1024), '0);
    hold_off(random_gap());
    send_angles('0, ANGLE_BITS'(1023));
    send_angles('0, ANGLE_BITS'(1024));
    // last count of sector zero and first of sector one with one pole pair
    send_angles(ANGLE_BITS'(900), ANGLE_BITS'(682));
    send_angles(ANGLE_BITS'(400), ANGLE_BITS'(683));

    wait_idle();
    // zero gain: both driven legs at zero, enables still set
    write_register(CFG_GAIN, 16'd0);
    send_angles(ANGLE_BITS'(ANGLE_TOP), '0);

    wait_idle();
    // all-ones data: offset keeps its low twelve bits, pole pairs zero
    write_register(CFG_GAIN, 16'hFFFF);
    write_register(CFG_OFFSET, 16'hFFFF);
    write_register(CFG_POLES, 16'd0);
    send_angles(ANGLE_BITS'(ANGLE_TOP), '0);
    send_angles('0, ANGLE_BITS'(ANGLE_TOP));

    wait_idle();
    // largest pole-pair count, 31, through truncation of all-ones data
    write_register(CFG_POLES, 16'hFFFF);
    send_angles(ANGLE_BITS'(2000), ANGLE_BITS'(ANGLE_TOP));
    send_angles(ANGLE_BITS'(1), ANGLE_BITS'(3000));

    wait_idle();
    write_register(CFG_POLES, 16'd16);
    // spare index, must leave every register alone
    write_register(CFG_SPARE, 16'h5A5A);
    send_angles(ANGLE_BITS'($urandom), ANGLE_BITS'($urandom));
    send_angles(ANGLE_BITS'($urandom), ANGLE_BITS'($urandom));

    wait_idle();
    write_register(CFG_GAIN, 16'(GAIN_RESET));
    write_register(CFG_OFFSET, 16'(OFFSET_RESET));
    write_register(CFG_POLES, 16'(POLES_RESET));
  endtask

  // new register values each phase, then a mix of full-range angles,
  // small errors of at most 128 either way, corners and zero error
  task automatic test_random_traffic();
    int          phase;
    int          n;
    int          pick;
    int          near_angle;
    bit          no_gaps;
    logic [CFG_DATA_BITS-1:0] value;
    logic [ANGLE_BITS-1:0]    ref_angle;
    logic [ANGLE_BITS-1:0]    meas_angle;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      pick = $urandom_range(0, 7);
      if (pick == 0) value = '0;
      else if (pick == 1) value = '1;
      else if (pick < 6) value = CFG_DATA_BITS'($urandom_range(1, 1023));
      else value = CFG_DATA_BITS'($urandom);
      write_register(CFG_GAIN, value);
      write_register(CFG_OFFSET, CFG_DATA_BITS'($urandom));
      value = CFG_DATA_BITS'($urandom_range(1, 16));
      if ($urandom_range(0, 3) == 0) value = CFG_DATA_BITS'($urandom);
      write_register(CFG_POLES, value);
      if ($urandom_range(0, 3) == 0) write_register(CFG_SPARE, CFG_DATA_BITS'($urandom));

      // some phases run without any pause at all
      no_gaps = ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 9);
        meas_angle = ANGLE_BITS'($urandom);
        ref_angle  = ANGLE_BITS'($urandom);
        if (pick >= 4 && pick < 8) begin
          near_angle = int'(meas_angle) + $urandom_range(0, 256) - 128;
          if (near_angle < 0) near_angle = 0;
          if (near_angle > ANGLE_TOP) near_angle = ANGLE_TOP;
          ref_angle = ANGLE_BITS'(near_angle);
        end else if (pick == 8) begin
          ref_angle  = $urandom_range(0, 1) ? ANGLE_BITS'(ANGLE_TOP) : '0;
          meas_angle = $urandom_range(0, 1) ? ANGLE_BITS'(ANGLE_TOP) : '0;
        end else if (pick == 9) begin
          ref_angle = meas_angle;
        end
        if (!no_gaps) hold_off(random_gap());
        send_angles(ref_angle, meas_angle);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned tail;
    rst             = 1'b1;
    start           = 1'b0;
    reference_angle = '0;
    measured_angle  = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_GAIN;
    cfg_data        = '0;
    gain_setting    = GAIN_RESET;
    offset_setting  = OFFSET_RESET;
    pole_setting    = POLES_RESET;
    mismatch_count  = 0;
    result_count    = 0;
    cycle_count     = 0;

    // reset held first, then released on a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_config();
    test_register_settings();
    test_random_traffic();

    @(negedge clk);
    start = 1'b0;
    // drain what is still in flight, then wait quietly for strays
    tail = 0;
    while (pending_commutations.size() > 0 && tail < 1000) begin
      @(posedge clk);
      tail++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (pending_commutations.size() > 0) begin
      report_mismatch($sformatf("%0d predicted results never arrived",
                                pending_commutations.size()));
    end

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
